// File: rtl/qfrv_pkg.sv
package qfrv_pkg;

   localparam logic [33:0]        Q30_ONE     = 34'd1073741824;
   localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [9:0]         THRESH_RESET = 10'd5;

   // three rotation components, x in the lowest slot
   typedef logic [2:0][31:0] vec_type;

   typedef struct packed {
      vec_type     v;
      logic [63:0] rad;
      logic [33:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      vec_type            v;
      logic [31:0]        theta;
      logic               small_angle;
      logic               flip;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_type;

   typedef struct packed {
      vec_type            v;
      logic [31:0]        theta;
      logic               small_angle;
      logic signed [33:0] w;
      logic [2:0]         neg;
      logic [2:0][63:0]   mag;
   } scale_type;

   typedef struct packed {
      vec_type            v;
      logic [31:0]        theta;
      logic               small_angle;
      logic signed [33:0] w;
      logic [2:0]         neg;
      logic [2:0][31:0]   rem;
      logic [2:0][31:0]   lo;
      logic [2:0][31:0]   quo;
   } div_type;

   // atan(2^-i) in Q.30
   function automatic logic signed [33:0] qfrv_atan(input logic [4:0] idx);
      case (idx)
         5'd0:  return 34'sd843314856;
         5'd1:  return 34'sd497837829;
         5'd2:  return 34'sd263043836;
         5'd3:  return 34'sd133525158;
         5'd4:  return 34'sd67021686;
         5'd5:  return 34'sd33543515;
         5'd6:  return 34'sd16775850;
         5'd7:  return 34'sd8388437;
         5'd8:  return 34'sd4194282;
         5'd9:  return 34'sd2097149;
         5'd10: return 34'sd1048575;
         5'd11: return 34'sd524287;
         5'd12: return 34'sd262143;
         5'd13: return 34'sd131071;
         5'd14: return 34'sd65535;
         5'd15: return 34'sd32767;
         5'd16: return 34'sd16383;
         5'd17: return 34'sd8191;
         5'd18: return 34'sd4095;
         5'd19: return 34'sd2047;
         5'd20: return 34'sd1023;
         5'd21: return 34'sd511;
         5'd22: return 34'sd255;
         5'd23: return 34'sd127;
         5'd24: return 34'sd63;
         5'd25: return 34'sd31;
         5'd26: return 34'sd15;
         5'd27: return 34'sd8;
         5'd28: return 34'sd4;
         5'd29: return 34'sd2;
         5'd30: return 34'sd1;
         default: return 34'sd0;
      endcase
   endfunction

endpackage

// File: rtl/quaternion_from_rotation_vector_unit.sv
// channel | ports     | fields (low bit up)
// --------+-----------+------------------------------------------------
// request | req_t*    | tdata: rot_x, rot_y, rot_z
// response| rsp_t*    | tdata: quat_w, quat_x, quat_y, quat_z; tuser: small_angle_used
// csr     | csr_wr_*  | small_angle_threshold
//
// One transaction per cycle while the response is not held. Registered in order: squares, their sum,
// the square root (one result bit per stage), the reduction, CORDIC_STAGES rotations, the product,
// the rounding, the divider (one quotient bit per stage) and the output.
// Synchronous reset clears the valid bits and sets the threshold to 5.
// A held response stalls the whole pipeline; nothing is dropped or repeated.
module quaternion_from_rotation_vector_unit #(
   parameter int CORDIC_STAGES = 24,
   parameter int DATA_WIDTH    = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [9:0]   csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // rot_x, rot_y, rot_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic         rsp_tuser    // small_angle_used
);
   import qfrv_pkg::*;

   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   function automatic logic [31:0] sat32(input logic signed [33:0] val);
      logic signed [63:0] e;
      e = 64'(val);
      if (e > SAT_HI) e = SAT_HI;
      else if (e < SAT_LO) e = SAT_LO;
      return e[31:0];
   endfunction

   logic adv;
   logic [9:0] thresh_ff;

   logic              sq_valid_ff;
   vec_type           sq_v_ff;
   logic [2:0][63:0]  sq_ff;
   logic signed [63:0] sq_in [3];

   logic        sum_valid_ff;
   vec_type     sum_v_ff;
   logic [63:0] sum_ff;

   sqrt_type   sqrt_ff       [32];
   logic       sqrt_valid_ff [32];
   cordic_type red_ff;
   logic       red_valid_ff;
   cordic_type cor_ff        [CORDIC_STAGES];
   logic       cor_valid_ff  [CORDIC_STAGES];
   scale_type  mul_ff, mul_in, rnd_ff, rnd_in;
   logic       mul_valid_ff, rnd_valid_ff;
   div_type    div_ff        [32];
   logic       div_valid_ff  [32];

   logic         rsp_valid_ff, rsp_small_ff, rsp_small_in;
   logic [127:0] rsp_data_ff, rsp_data_in;
   cordic_type   red_in;

   assign adv        = ~rsp_valid_ff | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // squares
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = signed'(req_tdata[32*k +: 32]) * signed'(req_tdata[32*k +: 32]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (adv) begin
         sq_valid_ff  <= req_tvalid;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_v_ff  <= req_tdata;
         for (int k = 0; k < 3; k++) sq_ff[k] <= sq_in[k];
         sum_v_ff <= sq_v_ff;
         sum_ff   <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   // integer square root, two radicand bits per stage
   for (genvar k = 0; k < 32; k++) begin : g_sqrt
      sqrt_type    cur, sqrt_in;
      logic        cur_valid;
      logic [35:0] rem2, trial;
      if (k == 0) begin : g_first
         always_comb begin
            cur      = '0;
            cur.v    = sum_v_ff;
            cur.rad  = sum_ff;
         end
         assign cur_valid = sum_valid_ff;
      end else begin : g_next
         assign cur       = sqrt_ff[k-1];
         assign cur_valid = sqrt_valid_ff[k-1];
      end
      always_comb begin
         rem2    = {cur.rem, cur.rad[63:62]};
         trial   = {2'b00, cur.root, 2'b01};
         sqrt_in = cur;
         sqrt_in.rad = {cur.rad[61:0], 2'b00};
         if (rem2 >= trial) begin
            sqrt_in.rem  = 34'(rem2 - trial);
            sqrt_in.root = {cur.root[30:0], 1'b1};
         end else begin
            sqrt_in.rem  = rem2[33:0];
            sqrt_in.root = {cur.root[30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sqrt_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            sqrt_valid_ff[k] <= cur_valid;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) sqrt_ff[k] <= sqrt_in;
      end
   end

   // reduce the half-angle about pi/2
   always_comb begin
      red_in             = '0;
      red_in.v           = sqrt_ff[31].v;
      red_in.theta       = sqrt_ff[31].root;
      red_in.small_angle = sqrt_ff[31].root < {22'd0, thresh_ff};
      red_in.flip        = signed'({2'b00, sqrt_ff[31].root}) > Q30_HALF_PI;
      red_in.x           = CORDIC_GAIN;
      red_in.y           = '0;
      red_in.z           = red_in.flip ? Q30_PI - signed'({2'b00, sqrt_ff[31].root})
                                       : signed'({2'b00, sqrt_ff[31].root});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_valid_ff <= 1'b0;
      end else if (adv) begin
         red_valid_ff <= sqrt_valid_ff[31];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) red_ff <= red_in;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      cordic_type         cur, cor_in;
      logic               cur_valid;
      logic signed [33:0] dx, dy;
      if (i == 0) begin : g_first
         assign cur       = red_ff;
         assign cur_valid = red_valid_ff;
      end else begin : g_next
         assign cur       = cor_ff[i-1];
         assign cur_valid = cor_valid_ff[i-1];
      end
      always_comb begin
         dx     = signed'(cur.y) >>> i;
         dy     = signed'(cur.x) >>> i;
         cor_in = cur;
         if (!cur.z[33]) begin
            cor_in.x = cur.x - dx;
            cor_in.y = cur.y + dy;
            cor_in.z = cur.z - qfrv_atan(5'(i));
         end else begin
            cor_in.x = cur.x + dx;
            cor_in.y = cur.y - dy;
            cor_in.z = cur.z + qfrv_atan(5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cor_valid_ff[i] <= 1'b0;
         end else if (adv) begin
            cor_valid_ff[i] <= cur_valid;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) cor_ff[i] <= cor_in;
      end
   end

   // v * sin, split into sign and magnitude for the divider
   always_comb begin
      logic signed [31:0] s;
      logic signed [63:0] prod;
      s                  = signed'(cor_ff[CORDIC_STAGES-1].y[31:0]);
      mul_in             = '0;
      mul_in.v           = cor_ff[CORDIC_STAGES-1].v;
      mul_in.theta       = cor_ff[CORDIC_STAGES-1].theta;
      mul_in.small_angle = cor_ff[CORDIC_STAGES-1].small_angle;
      mul_in.w           = cor_ff[CORDIC_STAGES-1].flip ? -cor_ff[CORDIC_STAGES-1].x
                                                        : cor_ff[CORDIC_STAGES-1].x;
      for (int k = 0; k < 3; k++) begin
         prod           = signed'(cor_ff[CORDIC_STAGES-1].v[k]) * s;
         mul_in.neg[k]  = prod[63];
         mul_in.mag[k]  = prod[63] ? 64'(-prod) : 64'(prod);
      end
   end

   // add theta/2 so the divider rounds to nearest
   always_comb begin
      rnd_in = mul_ff;
      for (int k = 0; k < 3; k++) begin
         rnd_in.mag[k] = mul_ff.mag[k] + {33'd0, mul_ff.theta[31:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rnd_valid_ff <= 1'b0;
      end else if (adv) begin
         mul_valid_ff <= cor_valid_ff[CORDIC_STAGES-1];
         rnd_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_ff <= mul_in;
         rnd_ff <= rnd_in;
      end
   end

   // restoring divide by theta, one quotient bit per stage
   for (genvar j = 0; j < 32; j++) begin : g_div
      div_type         cur, div_in;
      logic            cur_valid;
      logic [2:0][32:0] rem2;
      logic [2:0]      ge;
      if (j == 0) begin : g_first
         always_comb begin
            cur             = '0;
            cur.v           = rnd_ff.v;
            cur.theta       = rnd_ff.theta;
            cur.small_angle = rnd_ff.small_angle;
            cur.w           = rnd_ff.w;
            cur.neg         = rnd_ff.neg;
            for (int k = 0; k < 3; k++) begin
               cur.rem[k] = rnd_ff.mag[k][63:32];
               cur.lo[k]  = rnd_ff.mag[k][31:0];
            end
         end
         assign cur_valid = rnd_valid_ff;
      end else begin : g_next
         assign cur       = div_ff[j-1];
         assign cur_valid = div_valid_ff[j-1];
      end
      always_comb begin
         div_in = cur;
         for (int k = 0; k < 3; k++) begin
            rem2[k] = {cur.rem[k], cur.lo[k][31]};
            ge[k]   = rem2[k] >= {1'b0, cur.theta};
            div_in.rem[k] = ge[k] ? 32'(rem2[k] - {1'b0, cur.theta}) : rem2[k][31:0];
            div_in.lo[k]  = {cur.lo[k][30:0], 1'b0};
            div_in.quo[k] = {cur.quo[k][30:0], ge[k]};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            div_valid_ff[j] <= cur_valid;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) div_ff[j] <= div_in;
      end
   end

   // Small-angle form: theta < 1024 keeps the sum far below 2^31, so the norm of
   // (1, v) is exactly 2^30 in Q1.30 and the result is (1, v) with v passed through raw.
   always_comb begin
      logic signed [33:0] part;
      rsp_small_in = div_ff[31].small_angle;
      if (div_ff[31].small_angle) begin
         rsp_data_in[31:0] = sat32(signed'(Q30_ONE));
      end else begin
         rsp_data_in[31:0] = sat32(div_ff[31].w);
      end
      for (int k = 0; k < 3; k++) begin
         if (div_ff[31].small_angle) begin
            part = 34'(signed'(div_ff[31].v[k]));
         end else if (div_ff[31].theta == '0) begin
            part = '0;
         end else if (div_ff[31].neg[k]) begin
            part = -signed'({2'b00, div_ff[31].quo[k]});
         end else begin
            part = signed'({2'b00, div_ff[31].quo[k]});
         end
         rsp_data_in[32*(k+1) +: 32] = sat32(part);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid_ff[31];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_small_ff <= rsp_small_in;
      end
   end

endmodule

// File: rtl/qfrv_checker.sv
module qfrv_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser
);
   import qfrv_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow output stall");

   // small-angle results carry the raw vector, which stays within +-1023
   a_small_parts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[63:42] == '0 || rsp_tdata[63:42] == '1) &&
         (rsp_tdata[95:74] == '0 || rsp_tdata[95:74] == '1) &&
         (rsp_tdata[127:106] == '0 || rsp_tdata[127:106] == '1))
      else $error("small-angle vector part out of range");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   if (DATA_WIDTH >= 32) begin : g_small_w
      a_small_w: assert property (@(posedge clock) disable iff (reset)
         rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == Q30_ONE[31:0])
         else $error("small-angle scalar part is not one");
   end

endmodule

bind quaternion_from_rotation_vector_unit qfrv_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qfrv_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
